// ----- src/dwcw_pkg.sv -----
// dwcw_pkg: shared constants, types and the base decoder of the dna w-curve walk unit
// depends on nothing; every other file of the block uses it by scoped names
`timescale 1ns / 1ps

package dwcw_pkg;

  // coordinate format
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_W       = 32;

  // register and field widths
  localparam int SCALE_W   = 25;
  localparam int DIVISOR_W = 16;
  localparam int ZSTEP_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // stream widths
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 104;

  // g +/- pos in signed form, with room for the carry
  localparam int EXT_W     = ((COORD_WIDTH > SCALE_W) ? COORD_WIDTH : SCALE_W) + 2;
  // divider: quotient bits retired per cycle
  localparam int DIV_BITS  = 2;
  localparam int MAG_W     = ((EXT_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_ITERS = MAG_W / DIV_BITS;
  localparam int CNT_W     = $clog2(DIV_ITERS + 1);
  localparam int QUO_W     = MAG_W + 1;
  localparam int SUM_W     = MAG_W + 2;

  // register indexes
  localparam logic [1:0] REG_CORNER_SCALE = 2'd0;
  localparam logic [1:0] REG_STEP_DIVISOR = 2'd1;
  localparam logic [1:0] REG_Z_STEP       = 2'd2;

  // register reset values
  localparam logic [SCALE_W-1:0]   CORNER_SCALE_RST = SCALE_W'(1) << FRAC_BITS;
  localparam logic [DIVISOR_W-1:0] STEP_DIVISOR_RST = DIVISOR_W'(2);
  localparam logic [ZSTEP_W-1:0]   Z_STEP_RST       = ZSTEP_W'(1) << FRAC_BITS;

  // base codes
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // ascii characters
  localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

  typedef struct packed {
    logic       is_base;
    logic [1:0] code;
  } base_dec_t;

  typedef struct packed {
    logic [SCALE_W-1:0]   corner_scale;
    logic [DIVISOR_W-1:0] divisor;      // zero already replaced by one
    logic [ZSTEP_W-1:0]   z_step;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_START,
    ST_DIV,
    ST_FIX,
    ST_UPDATE,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic calc_diff;
    logic start_div;
    logic fix_sign;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_base;
    logic div_done;
  } stat_t;

  // character to base code, either case
  function automatic base_dec_t decode_base(input logic [CHAR_W-1:0] ch);
    base_dec_t d;
    d.is_base = 1'b1;
    d.code    = BASE_A;
    case (ch)
      CHAR_A_UP, CHAR_A_LO: d.code = BASE_A;
      CHAR_C_UP, CHAR_C_LO: d.code = BASE_C;
      CHAR_G_UP, CHAR_G_LO: d.code = BASE_G;
      CHAR_T_UP, CHAR_T_LO: d.code = BASE_T;
      default: begin
        d.is_base = 1'b0;
        d.code    = BASE_A;
      end
    endcase
    return d;
  endfunction

endpackage

// ----- src/dwcw_regs.sv -----
// dwcw_regs: apb-style configuration registers (corner scale, step divisor, z step)
// depends on dwcw_pkg
`timescale 1ns / 1ps

module dwcw_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dwcw_pkg::ADDR_W-1:0] paddr,
  input  logic [dwcw_pkg::DATA_W-1:0] pwdata,
  output logic [dwcw_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output dwcw_pkg::cfg_t             cfg_o
);

  logic [dwcw_pkg::SCALE_W-1:0]   corner_scale_q;
  logic [dwcw_pkg::DIVISOR_W-1:0] step_divisor_q;
  logic [dwcw_pkg::ZSTEP_W-1:0]   z_step_q;
  logic [1:0]                     reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_scale_q <= dwcw_pkg::CORNER_SCALE_RST;
      step_divisor_q <= dwcw_pkg::STEP_DIVISOR_RST;
      z_step_q       <= dwcw_pkg::Z_STEP_RST;
    end else if (wr_en) begin
      if (reg_idx == dwcw_pkg::REG_CORNER_SCALE) begin
        corner_scale_q <= pwdata[dwcw_pkg::SCALE_W-1:0];
      end
      if (reg_idx == dwcw_pkg::REG_STEP_DIVISOR) begin
        step_divisor_q <= pwdata[dwcw_pkg::DIVISOR_W-1:0];
      end
      if (reg_idx == dwcw_pkg::REG_Z_STEP) begin
        z_step_q <= pwdata[dwcw_pkg::ZSTEP_W-1:0];
      end
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      dwcw_pkg::REG_CORNER_SCALE: prdata = dwcw_pkg::DATA_W'(corner_scale_q);
      dwcw_pkg::REG_STEP_DIVISOR: prdata = dwcw_pkg::DATA_W'(step_divisor_q);
      dwcw_pkg::REG_Z_STEP:       prdata = dwcw_pkg::DATA_W'(z_step_q);
      default:                    prdata = '0;
    endcase
  end

  // a zero divisor behaves as one
  assign cfg_o.corner_scale = corner_scale_q;
  assign cfg_o.divisor      = (step_divisor_q == '0) ? dwcw_pkg::DIVISOR_W'(1) : step_divisor_q;
  assign cfg_o.z_step       = z_step_q;

endmodule

// ----- src/dwcw_div.sv -----
// dwcw_div: iterative unsigned restoring divider, DIV_BITS quotient bits per cycle
// depends on dwcw_pkg
`timescale 1ns / 1ps

module dwcw_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dwcw_pkg::MAG_W-1:0]     dividend_i,
  input  logic [dwcw_pkg::DIVISOR_W-1:0] divisor_i,
  output logic [dwcw_pkg::MAG_W-1:0]     quotient_o,
  output logic                          done_o
);

  localparam int RW = dwcw_pkg::DIVISOR_W + 1;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [dwcw_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [RW-1:0]                 rem_q, rem_d;
  logic [dwcw_pkg::MAG_W-1:0]     quo_q, quo_d;
  logic [dwcw_pkg::DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [RW-1:0]                 rem_s;
  logic [dwcw_pkg::MAG_W-1:0]     quo_s;

  // DIV_BITS restoring steps: shift in a dividend bit, subtract when it fits
  always_comb begin
    rem_s = rem_q;
    quo_s = quo_q;
    for (int i = 0; i < dwcw_pkg::DIV_BITS; i++) begin
      rem_s = {rem_s[RW-2:0], quo_s[dwcw_pkg::MAG_W-1]};
      quo_s = {quo_s[dwcw_pkg::MAG_W-2:0], 1'b0};
      if (rem_s >= {1'b0, dvs_q}) begin
        rem_s    = rem_s - {1'b0, dvs_q};
        quo_s[0] = 1'b1;
      end
    end
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = dwcw_pkg::CNT_W'(dwcw_pkg::DIV_ITERS);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = rem_s;
      quo_d = quo_s;
      cnt_d = cnt_q - dwcw_pkg::CNT_W'(1);
      if (cnt_q == dwcw_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ----- src/dwcw_datapath.sv -----
// dwcw_datapath: walk position registers, corner distance, sign handling, saturation
// and the output register; depends on dwcw_pkg and dwcw_div
`timescale 1ns / 1ps

module dwcw_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dwcw_pkg::cfg_t                  cfg_i,
  input  dwcw_pkg::cmd_t                  cmd_i,
  output dwcw_pkg::stat_t                 stat_o,
  input  logic [dwcw_pkg::CHAR_W-1:0]      base_char_i,
  output logic                            accepted_o,
  output logic [dwcw_pkg::TDATA_OUT_W-1:0] result_o
);

  localparam int CW = dwcw_pkg::COORD_WIDTH;
  localparam int EW = dwcw_pkg::EXT_W;
  localparam int MW = dwcw_pkg::MAG_W;
  localparam int QW = dwcw_pkg::QUO_W;
  localparam int SW = dwcw_pkg::SUM_W;

  logic [dwcw_pkg::CHAR_W-1:0] char_q;
  dwcw_pkg::base_dec_t         dec;
  logic signed [CW-1:0]        walk_x_q, walk_y_q;
  logic [CW-1:0]               walk_z_q;
  logic signed [EW-1:0]        sx_q, sy_q;
  logic                        negx_q, negy_q;
  logic signed [QW-1:0]        qx_q, qy_q;
  logic signed [EW-1:0]        g_ext, px_ext, py_ext;
  logic [EW-1:0]               absx, absy;
  logic [MW-1:0]               quo_x, quo_y;
  logic                        done_x, done_y;
  logic signed [SW-1:0]        sum_x, sum_y;
  logic                        acc_q;
  logic [1:0]                  code_q;
  logic [dwcw_pkg::OUT_W-1:0]  out_x_q, out_y_q, out_z_q;

  // saturate a widened sum to the coordinate range
  function automatic logic [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
    logic [SW-CW:0] top;
    top = v[SW-1:CW-1];
    if ((&top) || !(|top)) begin
      return v[CW-1:0];
    end else if (v[SW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  assign dec            = dwcw_pkg::decode_base(char_q);
  assign stat_o.is_base = dec.is_base;
  assign stat_o.div_done = done_x & done_y;

  // s = g - pos towards a positive corner, g + pos towards a negative one
  assign g_ext  = EW'(signed'({1'b0, cfg_i.corner_scale}));
  assign px_ext = EW'(walk_x_q);
  assign py_ext = EW'(walk_y_q);

  // magnitudes for the dividers
  assign absx = sx_q[EW-1] ? EW'(-sx_q) : EW'(sx_q);
  assign absy = sy_q[EW-1] ? EW'(-sy_q) : EW'(sy_q);

  dwcw_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (MW'(absx)),
    .divisor_i  (cfg_i.divisor),
    .quotient_o (quo_x),
    .done_o     (done_x)
  );

  dwcw_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (MW'(absy)),
    .divisor_i  (cfg_i.divisor),
    .quotient_o (quo_y),
    .done_o     (done_y)
  );

  assign sum_x = SW'(walk_x_q) + SW'(qx_q);
  assign sum_y = SW'(walk_y_q) + SW'(qy_q);

  // character capture and per-step working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      char_q <= base_char_i;
    end
    if (cmd_i.calc_diff) begin
      sx_q <= dec.code[1] ? (g_ext - px_ext) : (g_ext + px_ext);
      sy_q <= dec.code[0] ? (g_ext - py_ext) : (g_ext + py_ext);
    end
    // the difference is -s towards a negative corner
    if (cmd_i.start_div) begin
      negx_q <= dec.code[1] ? sx_q[EW-1] : ~sx_q[EW-1];
      negy_q <= dec.code[0] ? sy_q[EW-1] : ~sy_q[EW-1];
    end
    if (cmd_i.fix_sign) begin
      qx_q <= negx_q ? -signed'({1'b0, quo_x}) : signed'({1'b0, quo_x});
      qy_q <= negy_q ? -signed'({1'b0, quo_y}) : signed'({1'b0, quo_y});
    end
  end

  // walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q <= '0;
      walk_y_q <= '0;
      walk_z_q <= '0;
    end else if (cmd_i.update) begin
      walk_x_q <= sat_coord(sum_x);
      walk_y_q <= sat_coord(sum_y);
      walk_z_q <= walk_z_q + CW'(signed'(cfg_i.z_step));
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      acc_q   <= dec.is_base;
      code_q  <= dec.is_base ? dec.code : dwcw_pkg::BASE_A;
      out_x_q <= dwcw_pkg::OUT_W'(walk_x_q);
      out_y_q <= dwcw_pkg::OUT_W'(walk_y_q);
      out_z_q <= dwcw_pkg::OUT_W'(signed'(walk_z_q));
    end
  end

  assign accepted_o = acc_q;
  assign result_o   = {3'b000,
                       acc_q & (code_q == dwcw_pkg::BASE_C || code_q == dwcw_pkg::BASE_T),
                       acc_q & (code_q == dwcw_pkg::BASE_G),
                       acc_q & (code_q == dwcw_pkg::BASE_A || code_q == dwcw_pkg::BASE_T),
                       out_z_q, out_y_q, out_x_q, code_q};

endmodule

// ----- src/dwcw_ctrl.sv -----
// dwcw_ctrl: sequencing state machine and output valid flag
// depends on dwcw_pkg
`timescale 1ns / 1ps

module dwcw_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  dwcw_pkg::stat_t stat_i,
  output dwcw_pkg::cmd_t  cmd_o
);

  dwcw_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dwcw_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = dwcw_pkg::ST_DECODE;
      end
      dwcw_pkg::ST_DECODE: begin
        state_d = stat_i.is_base ? dwcw_pkg::ST_DIV_START : dwcw_pkg::ST_WRITE;
      end
      dwcw_pkg::ST_DIV_START: state_d = dwcw_pkg::ST_DIV;
      dwcw_pkg::ST_DIV: begin
        if (stat_i.div_done) state_d = dwcw_pkg::ST_FIX;
      end
      dwcw_pkg::ST_FIX:    state_d = dwcw_pkg::ST_UPDATE;
      dwcw_pkg::ST_UPDATE: state_d = dwcw_pkg::ST_WRITE;
      dwcw_pkg::ST_WRITE: begin
        if (out_free) state_d = dwcw_pkg::ST_IDLE;
      end
      default: state_d = dwcw_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dwcw_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      dwcw_pkg::ST_DECODE:    cmd_o.calc_diff = stat_i.is_base;
      dwcw_pkg::ST_DIV_START: cmd_o.start_div = 1'b1;
      dwcw_pkg::ST_DIV:       cmd_o           = '0;
      dwcw_pkg::ST_FIX:       cmd_o.fix_sign  = 1'b1;
      dwcw_pkg::ST_UPDATE:    cmd_o.update    = 1'b1;
      dwcw_pkg::ST_WRITE:     cmd_o.load_out  = out_free;
      default:                cmd_o           = '0;
    endcase
  end

  // result held until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dwcw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/dna_w_curve_walk_unit.sv -----
// A base character passes through decode, divider start, division, sign fix, walk
// update and write; any other character goes from decode straight to write. One item
// is taken at a time, and the division is done by the two parallel dividers
// retiring 2 quotient bits a cycle (17 steps); a result not yet taken stalls the next.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_ni low, asynchronous) clears the walk position to zero and loads the
// registers with corner scale 1.0, step divisor 2 and z step 1.0.
`timescale 1ns / 1ps

module dna_w_curve_walk_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dwcw_pkg::ADDR_W-1:0]      paddr,
  input  logic [dwcw_pkg::DATA_W-1:0]      pwdata,
  output logic [dwcw_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dwcw_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // base_char[7:0]
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // base_code[1:0], point_x[33:2], point_y[65:34], point_z[97:66],
  // colour_red[98], colour_green[99], colour_blue[100], zero[103:101]
  output logic [dwcw_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser   // accepted
);

  dwcw_pkg::cfg_t  cfg;
  dwcw_pkg::cmd_t  cmd;
  dwcw_pkg::stat_t stat;

  dwcw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dwcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dwcw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .base_char_i (s_axis_tdata),
    .accepted_o  (m_axis_tuser),
    .result_o    (m_axis_tdata)
  );

endmodule
